>>> rtl/core/tpsm_pkg.sv
package tpsm_pkg;

    localparam int CHANNELS = 6;
    localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    localparam int IN_W  = 40;
    localparam int OUT_W = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // item ops
    localparam logic [1:0] OP_TICK = 2'd0;
    localparam logic [1:0] OP_MOVE = 2'd1;
    localparam logic [1:0] OP_POLL = 2'd2;

    // positions
    localparam logic [1:0] POS_STRAIGHT     = 2'd0;
    localparam logic [1:0] POS_DIVERGED     = 2'd1;
    localparam logic [1:0] POS_UNDETERMINED = 2'd2;
    localparam logic [1:0] POS_CONFLICT     = 2'd3;
    localparam logic [2:0] LAST_POS_NONE    = 3'd7;

    // statuses
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_BLOCKED = 2'd1;
    localparam logic [1:0] ST_ERROR   = 2'd2;
    localparam logic [1:0] ST_NONE    = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_REPORT_PERIOD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FALLBACK      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FLOOR         = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CEILING       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MARGIN        = 3'd4;

    localparam logic [15:0] RST_REPORT_PERIOD = 16'd200;
    localparam logic [12:0] RST_FALLBACK      = 13'd800;
    localparam logic [11:0] RST_FLOOR         = 12'd200;
    localparam logic [11:0] RST_CEILING       = 12'd1500;
    localparam logic [11:0] RST_MARGIN        = 12'd200;

    typedef struct packed {
        logic        any_moving;
        logic [1:0]  worst_status;
        logic [1:0]  report_status;
        logic [1:0]  report_position;
        logic [3:0]  report_channel;
        logic        report_valid;
    } result_t;

    function automatic logic [1:0] decode_position(input logic straight_n,
                                                   input logic diverged_n);
        logic [1:0] pos;
        unique case ({straight_n, diverged_n})
            2'b01:   pos = POS_STRAIGHT;
            2'b10:   pos = POS_DIVERGED;
            2'b11:   pos = POS_UNDETERMINED;
            default: pos = POS_CONFLICT;
        endcase
        return pos;
    endfunction

endpackage

>>> rtl/core/turnout_position_stall_monitor.sv
// Turnout position and stall monitor.
// Input channel s_*: one 40-bit word per item (op, channel, two active-low
// limit switch levels, current and target servo pulse widths). Op tick
// advances the millisecond counter, op move arms the channel's stall timer,
// op poll decodes the switches, updates the channel's status and reports on
// a change or when the report period has run out.
// Output channel m_*: exactly one result word per item, carrying the report
// (valid flag, channel, position, status) plus the worst status over all
// channels and whether any channel is still moving, both after the update.
// The state is updated and the result register loaded at the edge that accepts
// the item. Throughput is one item per cycle; the limit is the single result
// register, so s_tready follows m_tready while a result is held and a stalled
// receiver stalls the input one for one.
// Configuration: cfg_wr_en/cfg_index/cfg_data write one register per edge; the
// user must write only while no item is in flight, the block does not enforce it.
// Reset clears the counter, marks every channel as never reported and not
// moving, loads the register defaults and empties the result register.
module turnout_position_stall_monitor (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // op[1:0], channel[5:2], straight_switch_n[6], diverged_switch_n[7],
    // current_pulse[23:8], target_pulse[39:24]
    input  logic [tpsm_pkg::IN_W-1:0]           s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // report_valid[0], report_channel[4:1], report_position[6:5],
    // report_status[8:7], worst_status[10:9], any_moving[11], zeros above
    output logic [tpsm_pkg::OUT_W-1:0]          m_tdata,
    input  logic                                cfg_wr_en,
    input  logic [tpsm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tpsm_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int NCH = tpsm_pkg::CHANNELS;
    localparam int IW  = tpsm_pkg::CH_IDX_W;

    logic [15:0] report_period_reg;
    logic [12:0] fallback_reg;
    logic [11:0] floor_reg;
    logic [11:0] ceiling_reg;
    logic [11:0] margin_reg;

    logic [31:0] now_reg, now_next;
    logic [2:0]  last_pos_reg      [NCH];
    logic [1:0]  last_st_reg       [NCH];
    logic [31:0] last_report_reg   [NCH];
    logic [31:0] move_start_reg    [NCH];
    logic [12:0] move_limit_reg    [NCH];
    logic [NCH-1:0] moving_reg, moving_next;
    logic [1:0]  last_st_next      [NCH];

    logic                  out_valid_reg;
    tpsm_pkg::result_t     out_reg, out_next;

    logic        accept;
    logic [1:0]  op;
    logic [3:0]  channel;
    logic        straight_n, diverged_n;
    logic [15:0] cur_pulse, tgt_pulse;
    logic        ch_ok;
    logic [IW-1:0] idx;

    logic [15:0] diff;
    logic [15:0] half_clamped;
    logic [11:0] t_clamped;
    logic [12:0] limit;

    logic [1:0]  pos;
    logic [1:0]  st;
    logic [31:0] move_elapsed, report_elapsed;
    logic        changed, periodic;
    logic        do_move, do_poll, do_report;
    logic [1:0]  worst;

    assign op         = s_tdata[1:0];
    assign channel    = s_tdata[5:2];
    assign straight_n = s_tdata[6];
    assign diverged_n = s_tdata[7];
    assign cur_pulse  = s_tdata[23:8];
    assign tgt_pulse  = s_tdata[39:24];

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(tpsm_pkg::OUT_W - $bits(tpsm_pkg::result_t)){1'b0}}, out_reg};

    assign ch_ok = ({1'b0, channel} < 5'(NCH));
    assign idx   = channel[IW-1:0];

    // stall limit: |cur - tgt| / 2, floor then ceiling, plus margin; fallback if either pulse is 0
    always_comb
    begin
        diff = (cur_pulse > tgt_pulse) ? (cur_pulse - tgt_pulse) : (tgt_pulse - cur_pulse);
        half_clamped = {1'b0, diff[15:1]};
        if (half_clamped < {4'd0, floor_reg})
            half_clamped = {4'd0, floor_reg};
        if (half_clamped > {4'd0, ceiling_reg})
            t_clamped = ceiling_reg;
        else
            t_clamped = half_clamped[11:0];
        if (cur_pulse == 16'd0 || tgt_pulse == 16'd0)
            limit = fallback_reg;
        else
            limit = {1'b0, t_clamped} + {1'b0, margin_reg};
    end

    always_comb
    begin
        pos = tpsm_pkg::decode_position(straight_n, diverged_n);
        move_elapsed   = now_reg - move_start_reg[idx];
        report_elapsed = now_reg - last_report_reg[idx];
        if (pos == tpsm_pkg::POS_UNDETERMINED || pos == tpsm_pkg::POS_CONFLICT)
            st = tpsm_pkg::ST_ERROR;
        else if (moving_reg[idx] && move_elapsed > {19'd0, move_limit_reg[idx]})
            st = tpsm_pkg::ST_BLOCKED;
        else
            st = tpsm_pkg::ST_OK;
        changed  = ({1'b0, pos} != last_pos_reg[idx]) || (st != last_st_reg[idx]);
        periodic = report_elapsed >= {16'd0, report_period_reg};

        do_move   = accept && (op == tpsm_pkg::OP_MOVE) && ch_ok;
        do_poll   = accept && (op == tpsm_pkg::OP_POLL) && ch_ok;
        do_report = do_poll && (changed || periodic);

        now_next = now_reg;
        if (accept && op == tpsm_pkg::OP_TICK)
            now_next = now_reg + 32'd1;

        moving_next = moving_reg;
        for (int i = 0; i < NCH; i++)
        begin
            last_st_next[i] = last_st_reg[i];
            if (idx == IW'(i))
            begin
                if (do_move)
                    moving_next[i] = 1'b1;
                else if (do_poll && st == tpsm_pkg::ST_OK)
                    moving_next[i] = 1'b0;
                if (do_report)
                    last_st_next[i] = st;
            end
        end

        worst = tpsm_pkg::ST_OK;
        for (int i = 0; i < NCH; i++)
        begin
            if (last_st_next[i] == tpsm_pkg::ST_BLOCKED)
                worst = tpsm_pkg::ST_BLOCKED;
            else if (last_st_next[i] == tpsm_pkg::ST_ERROR && worst != tpsm_pkg::ST_BLOCKED)
                worst = tpsm_pkg::ST_ERROR;
        end

        out_next.report_valid    = do_report;
        out_next.report_channel  = do_report ? channel : 4'd0;
        out_next.report_position = do_report ? pos : 2'd0;
        out_next.report_status   = do_report ? st : 2'd0;
        out_next.worst_status    = worst;
        out_next.any_moving      = |moving_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            report_period_reg <= tpsm_pkg::RST_REPORT_PERIOD;
            fallback_reg      <= tpsm_pkg::RST_FALLBACK;
            floor_reg         <= tpsm_pkg::RST_FLOOR;
            ceiling_reg       <= tpsm_pkg::RST_CEILING;
            margin_reg        <= tpsm_pkg::RST_MARGIN;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                tpsm_pkg::CFG_REPORT_PERIOD: report_period_reg <= cfg_data;
                tpsm_pkg::CFG_FALLBACK:      fallback_reg      <= cfg_data[12:0];
                tpsm_pkg::CFG_FLOOR:         floor_reg         <= cfg_data[11:0];
                tpsm_pkg::CFG_CEILING:       ceiling_reg       <= cfg_data[11:0];
                tpsm_pkg::CFG_MARGIN:        margin_reg        <= cfg_data[11:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            now_reg    <= '0;
            moving_reg <= '0;
            for (int i = 0; i < NCH; i++)
            begin
                last_pos_reg[i]    <= tpsm_pkg::LAST_POS_NONE;
                last_st_reg[i]     <= tpsm_pkg::ST_NONE;
                last_report_reg[i] <= '0;
                move_start_reg[i]  <= '0;
                move_limit_reg[i]  <= '0;
            end
        end
        else
        begin
            now_reg    <= now_next;
            moving_reg <= moving_next;
            for (int i = 0; i < NCH; i++)
            begin
                last_st_reg[i] <= last_st_next[i];
                if (idx == IW'(i))
                begin
                    if (do_move)
                    begin
                        move_start_reg[i] <= now_reg;
                        move_limit_reg[i] <= limit;
                    end
                    if (do_report)
                    begin
                        last_report_reg[i] <= now_reg;
                        last_pos_reg[i]    <= {1'b0, pos};
                    end
                end
            end
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s_tready)
            out_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            out_reg <= out_next;
    end

endmodule
